[sv/fjos_pkg.sv]
// Package for the flat JSON object scanner: event codes, result type,
// character constants and byte classification functions.
// Depends on nothing; used by every other file of the scanner.
package fjos_pkg;

  // Defaults for the length and nesting limits.
  localparam int MAX_VALUE_LEN_DEF = 255;
  localparam int MAX_NAME_LEN_DEF  = 255;
  localparam int MAX_DEPTH_DEF     = 255;

  // Structural characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // Command codes.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [2:0] {
    EV_NAME   = 3'd0,
    EV_VALUE  = 3'd1,
    EV_COMMIT = 3'd2,
    EV_DONE   = 3'd3,
    EV_ABORT  = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] ch;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], 8'h20};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
  endfunction

endpackage

[sv/fjos_out_queue.sv]
// Two-entry result queue that sits between the scanner and its consumer.
// Depends on fjos_pkg for the result type.
module fjos_out_queue
  import fjos_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    head;
  result_t    tail;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // A push never meets a full queue, since the producer waits on full.
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      head <= tail;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      head <= push_data;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      tail <= push_data;
    end
  end

endmodule

[sv/flat_json_object_scanner_unit.sv]
// Top level of the flat JSON object scanner: parser state machine and counters.
// Depends on fjos_pkg and fjos_out_queue.
//
//   Channel  Handshake            Payload                Direction
//   -------  -------------------  ---------------------  ---------
//   input    in_valid / in_ready  command, byte_in       to block
//   output   out_valid/out_ready  event_kind, char_out   from block
//
// Each accepted byte is scanned in the cycle of its transfer; its result, if
// any, goes into a two-entry result queue and is shown from its head. The
// block takes one byte per cycle, and still takes a byte while one result
// waits; in_ready drops only when both entries are held.
// Reset (rst, synchronous, active high) puts the parser in its begin state,
// clears the counters and empties the queue.
module flat_json_object_scanner_unit
  import fjos_pkg::*;
#(
  parameter int MAX_VALUE_LEN = MAX_VALUE_LEN_DEF,
  parameter int MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
  parameter int MAX_DEPTH     = MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] char_out
);

  // Counter widths follow from the limits: each counter must hold the limit.
  localparam int VW = $clog2(MAX_VALUE_LEN + 1);
  localparam int NW = $clog2(MAX_NAME_LEN + 1);
  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_BEGIN  = 4'd0,
    ST_NAME   = 4'd1,
    ST_COLON  = 4'd2,
    ST_DETECT = 4'd3,
    ST_INT    = 4'd4,
    ST_STRING = 4'd5,
    ST_OBJECT = 4'd6,
    ST_ARRAY  = 4'd7,
    ST_ENDING = 4'd8,
    ST_DONE   = 4'd9
  } scan_state_t;

  // quote_depth counts quotes while in a name, and bracket or brace depth
  // while inside a nested value.
  scan_state_t   scan_state, scan_state_next;
  logic [DW-1:0] quote_depth, quote_depth_next;
  logic [VW-1:0] value_length, value_length_next;
  logic [NW-1:0] name_length, name_length_next;

  logic    accept;
  logic    queue_full;
  logic    res_valid;
  result_t res;
  result_t head;

  // Helper flags raised by the state decode and resolved below it.
  logic vchar;     // byte is a value character (counted, may overflow)
  logic do_end;    // byte is handled by the value-ending rules
  logic do_abort;  // syntax error or limit exceeded

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    scan_state_next   = scan_state;
    quote_depth_next  = quote_depth;
    value_length_next = value_length;
    name_length_next  = name_length;
    res_valid         = 1'b0;
    res.kind          = EV_NAME;
    res.ch            = 8'h00;
    vchar             = 1'b0;
    do_end            = 1'b0;
    do_abort          = 1'b0;

    case (scan_state)
      ST_NAME: begin
        if (is_space(byte_in)) begin
          // Spaces are dropped, even inside the quotes of a name.
        end else if (byte_in == CH_QUOTE) begin
          if (quote_depth[0]) begin
            // Closing quote: an empty name is an error.
            if (name_length == '0) begin
              do_abort = 1'b1;
            end else begin
              quote_depth_next = '0;
              scan_state_next  = ST_COLON;
            end
          end else begin
            quote_depth_next = quote_depth + DW'(1);
          end
        end else if (is_punct(byte_in) || quote_depth != DW'(1)) begin
          do_abort = 1'b1;
        end else if (name_length >= NW'(MAX_NAME_LEN)) begin
          do_abort = 1'b1;
        end else begin
          name_length_next = name_length + NW'(1);
          res_valid        = 1'b1;
          res.kind         = EV_NAME;
          res.ch           = byte_in;
        end
      end
      ST_COLON: begin
        if (is_space(byte_in)) begin
        end else if (byte_in == CH_COLON) begin
          scan_state_next = ST_DETECT;
        end else begin
          do_abort = 1'b1;
        end
      end
      ST_DETECT: begin
        if (is_space(byte_in)) begin
        end else if (byte_in == CH_QUOTE) begin
          scan_state_next  = ST_STRING;
          quote_depth_next = DW'(1);
        end else if (byte_in == CH_LBRACE || byte_in == CH_LBRACK) begin
          scan_state_next  = (byte_in == CH_LBRACE) ? ST_OBJECT : ST_ARRAY;
          quote_depth_next = DW'(1);
          vchar            = 1'b1;
        end else if (is_digit(byte_in)) begin
          scan_state_next = ST_INT;
          vchar           = 1'b1;
        end else begin
          do_abort = 1'b1;
        end
      end
      ST_INT: begin
        if (is_space(byte_in)) begin
        end else if (is_digit(byte_in)) begin
          vchar = 1'b1;
        end else begin
          do_end = 1'b1;
        end
      end
      ST_STRING: begin
        // No escapes: the first quote closes the string, spaces are kept.
        if (byte_in == CH_QUOTE) begin
          quote_depth_next = '0;
          scan_state_next  = ST_ENDING;
        end else begin
          vchar = 1'b1;
        end
      end
      ST_OBJECT, ST_ARRAY: begin
        // Only the value's own kind of bracket changes the depth.
        if (is_space(byte_in)) begin
        end else if ((scan_state == ST_OBJECT && byte_in == CH_LBRACE) ||
                     (scan_state == ST_ARRAY && byte_in == CH_LBRACK)) begin
          if (quote_depth >= DW'(MAX_DEPTH)) begin
            do_abort = 1'b1;
          end else begin
            quote_depth_next = quote_depth + DW'(1);
            vchar            = 1'b1;
          end
        end else if ((scan_state == ST_OBJECT && byte_in == CH_RBRACE) ||
                     (scan_state == ST_ARRAY && byte_in == CH_RBRACK)) begin
          vchar = 1'b1;
          if (quote_depth <= DW'(1)) begin
            quote_depth_next = '0;
            scan_state_next  = ST_ENDING;
          end else begin
            quote_depth_next = quote_depth - DW'(1);
          end
        end else begin
          vchar = 1'b1;
        end
      end
      ST_ENDING: begin
        do_end = 1'b1;
      end
      ST_DONE: begin
        // Everything after the closing brace waits for a restart.
      end
      default: begin
        // Begin state: only an opening brace starts an object.
        if (byte_in == CH_LBRACE) begin
          scan_state_next   = ST_NAME;
          quote_depth_next  = '0;
          value_length_next = '0;
          name_length_next  = '0;
        end
      end
    endcase

    // Value ending: a comma commits the pair, a closing brace ends the object.
    if (do_end && !is_space(byte_in)) begin
      if ((byte_in == CH_COMMA || byte_in == CH_RBRACE) && value_length != '0) begin
        value_length_next = '0;
        name_length_next  = '0;
        quote_depth_next  = '0;
        scan_state_next   = (byte_in == CH_COMMA) ? ST_NAME : ST_DONE;
        res_valid         = 1'b1;
        res.kind          = (byte_in == CH_COMMA) ? EV_COMMIT : EV_DONE;
      end else begin
        do_abort = 1'b1;
      end
    end

    // Value character: counted against the value length limit.
    if (vchar) begin
      if (value_length >= VW'(MAX_VALUE_LEN)) begin
        do_abort = 1'b1;
      end else begin
        value_length_next = value_length + VW'(1);
        res_valid         = 1'b1;
        res.kind          = EV_VALUE;
        res.ch            = byte_in;
      end
    end

    // An abort overrides every update above it and tells downstream to drop
    // the object.
    if (do_abort) begin
      scan_state_next   = ST_BEGIN;
      quote_depth_next  = '0;
      value_length_next = '0;
      name_length_next  = '0;
      res_valid         = 1'b1;
      res.kind          = EV_ABORT;
      res.ch            = 8'h00;
    end

    // A restart command clears everything and gives no result.
    if (command == CMD_RESTART) begin
      scan_state_next   = ST_BEGIN;
      quote_depth_next  = '0;
      value_length_next = '0;
      name_length_next  = '0;
      res_valid         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state   <= ST_BEGIN;
      quote_depth  <= '0;
      value_length <= '0;
      name_length  <= '0;
    end else if (accept) begin
      scan_state   <= scan_state_next;
      quote_depth  <= quote_depth_next;
      value_length <= value_length_next;
      name_length  <= name_length_next;
    end
  end

  fjos_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign event_kind = head.kind;
  assign char_out   = head.ch;

endmodule

[sv/fjos_checker.sv]
// Port-level checker for the flat JSON object scanner, with its bind.
// Depends on fjos_pkg and on the ports of flat_json_object_scanner_unit.
module fjos_checker
  import fjos_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       command,
  input logic [7:0] byte_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_kind,
  input logic [7:0] char_out
);

  // The queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // A result that is not taken holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(char_out))
    else $error("stalled result changed");

  // With nothing queued the block always takes a byte.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result queue");

  // A restart gives no result.
  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_RESTART && !out_valid |=> !out_valid)
    else $error("restart produced a result");

  // Events without a character carry zero.
  a_zero_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_COMMIT || event_kind == EV_DONE ||
                  event_kind == EV_ABORT) |-> char_out == 8'h00)
    else $error("nonzero character on a structural event");

endmodule

bind flat_json_object_scanner_unit fjos_checker u_fjos_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .command    (command),
  .byte_in    (byte_in),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_kind (event_kind),
  .char_out   (char_out)
);
